// ===== hw/rtl/oasif_pkg.sv =====
// ----------------------------------------------------------------------------
// oasif_pkg: shared types and constants for the ordered array store
// Command and response words, mode and status codes, cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package oasif_pkg;

    // default configuration
    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths of the command and response words
    localparam int MODE_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 5;
    localparam int FILL_W   = 6;

    // command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 3'd0,
        MODE_APPEND = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_FIND   = 3'd3,
        MODE_READ   = 3'd4
    } mode_e;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BEYOND    = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_e;

    // command word
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } cmd_word_t;

    // response word
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [FOUND_W-1:0]        found_index;
        logic signed [VALUE_W-1:0] read_value;
        logic [FILL_W-1:0]         fill_count;
    } rsp_word_t;

    // broadcast control to every cell
    typedef struct packed {
        logic write;   // append or insert is committed this cycle
        logic insert;  // cells above the target shift up
        logic find;    // cells capture their compare result
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/oasif_cell.sv =====
// ----------------------------------------------------------------------------
// oasif_cell: one storage cell of the ordered array
// Holds one entry; loads the new word, takes its lower neighbor's entry on
// an insert shift, and registers its own compare result for a find.
// ----------------------------------------------------------------------------
`default_nettype none

module oasif_cell #(
    parameter int CAPACITY   = oasif_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = oasif_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0
) (
    input  wire logic                  clk,
    input  wire oasif_pkg::cell_ctl_t  ctl,
    input  wire logic [DATA_WIDTH-1:0] word,
    input  wire logic [DATA_WIDTH-1:0] prev_data,
    input  wire logic [(($clog2(CAPACITY+1) > oasif_pkg::POS_W) ?
                        $clog2(CAPACITY+1) : oasif_pkg::POS_W)-1:0] tgt,
    input  wire logic [(($clog2(CAPACITY+1) > oasif_pkg::POS_W) ?
                        $clog2(CAPACITY+1) : oasif_pkg::POS_W)-1:0] count,
    output logic      [DATA_WIDTH-1:0] data,
    output logic                       match
);
    import oasif_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic                  match_reg;
    logic                  load_word;
    logic                  take_prev;
    logic                  hit;

    // local decode of the broadcast command
    assign load_word = ctl.write && (MY_IDX == tgt);
    assign take_prev = ctl.write && ctl.insert && (MY_IDX > tgt) && (MY_IDX <= count);
    assign hit       = (data_reg == word) && (MY_IDX < count);

    // entry storage: no reset, read only below the fill count
    always_ff @(posedge clk)
    begin
        if (load_word)
        begin
            data_reg <= word;
        end
        else if (take_prev)
        begin
            data_reg <= prev_data;
        end
    end

    // compare result for the priority encoder
    always_ff @(posedge clk)
    begin
        if (ctl.find)
        begin
            match_reg <= hit;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_array_store_insert_find.sv =====
// ----------------------------------------------------------------------------
// ordered_array_store_insert_find: fixed-capacity ordered word store
// Chain of storage cells with a fill count; clear, append, insert, find
// and read commands, one response word per command word.
// ----------------------------------------------------------------------------
// When a command word is taken, the status is decided from the fill count,
// every cell shifts, loads or compares in parallel, and the read data and
// per-cell match bits are registered. When the response register is free or
// its word is taken, the staged match bits are priority-encoded into the
// lowest hit index and loaded into the response register. The match-bit
// register between the cells and the encoder holds one command, so the block
// takes no new command word until the staged one has moved into the response
// register. The store itself holds no reset value; only the fill count is
// cleared, and entries at or above it are never reported.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_store_insert_find #(
    parameter int CAPACITY   = oasif_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = oasif_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire oasif_pkg::cmd_word_t cmd,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output oasif_pkg::rsp_word_t      rsp
);
    import oasif_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    // control state
    logic                  s1_valid_reg;
    logic                  rsp_valid_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // first-stage payload
    logic                  s1_find_reg;
    logic [STATUS_W-1:0]   s1_status_reg;
    logic [VALUE_W-1:0]    s1_rd_reg;
    logic [FILL_W-1:0]     s1_fill_reg;
    rsp_word_t             rsp_reg;

    logic                  accept;
    logic                  advance;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      tgt;
    logic                  empty;
    logic                  full;
    logic [STATUS_W-1:0]   status_pre;
    logic [63:0]           val64;
    logic [DATA_WIDTH-1:0] word;
    cell_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]   match_vec;
    logic [DATA_WIDTH-1:0] rd_sel;
    logic [63:0]           rd64;
    logic [VALUE_W-1:0]    rd_word;
    logic [7:0]            fill8;
    logic                  enc_hit;
    logic [IDX_W-1:0]      enc_idx;
    logic [7:0]            found8;

    // handshake
    assign cmd_ready = !s1_valid_reg;
    assign accept    = cmd_valid && cmd_ready;
    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);

    // command decode against the current fill count
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(cmd.position);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign val64   = {32'b0, cmd.value};
    assign word    = val64[DATA_WIDTH-1:0];

    always_comb
    begin
        status_pre = ST_OK;
        case (cmd.mode)
            MODE_CLEAR:  status_pre = ST_OK;
            MODE_APPEND: status_pre = full ? ST_FULL : ST_OK;
            MODE_INSERT:
            begin
                if (empty)
                    status_pre = ST_EMPTY;
                else if (pos_ext > cnt_ext)
                    status_pre = ST_BEYOND;
                else if (full)
                    status_pre = ST_FULL;
                else
                    status_pre = ST_OK;
            end
            MODE_FIND:   status_pre = empty ? ST_EMPTY : ST_OK;
            MODE_READ:
            begin
                if (empty)
                    status_pre = ST_EMPTY;
                else if (pos_ext >= cnt_ext)
                    status_pre = ST_BEYOND;
                else
                    status_pre = ST_OK;
            end
            default:     status_pre = ST_OK;
        endcase
    end

    // cell control and fill count update
    always_comb
    begin
        ctl.write  = accept && (status_pre == ST_OK) &&
                     ((cmd.mode == MODE_APPEND) || (cmd.mode == MODE_INSERT));
        ctl.insert = (cmd.mode == MODE_INSERT);
        ctl.find   = accept && (cmd.mode == MODE_FIND);
        tgt        = ctl.insert ? pos_ext : cnt_ext;
        count_next = count_reg;
        if (accept && (cmd.mode == MODE_CLEAR))
            count_next = '0;
        else if (ctl.write)
            count_next = count_reg + CNT_W'(1);
    end

    // chain of cells; cell 0 has no lower neighbor and never shifts
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] prev_data;
        if (gi == 0)
        begin : g_first
            assign prev_data = word;
        end
        else
        begin : g_rest
            assign prev_data = cell_data[gi-1];
        end
        oasif_cell #(
            .CAPACITY   (CAPACITY),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (gi)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .word      (word),
            .prev_data (prev_data),
            .tgt       (tgt),
            .count     (cnt_ext),
            .data      (cell_data[gi]),
            .match     (match_vec[gi])
        );
    end

    // read select and sign extension to the response width
    assign rd_sel = cell_data[pos_ext[IDX_W-1:0]];
    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            rd64[i] = rd_sel[(i < DATA_WIDTH) ? i : DATA_WIDTH-1];
        end
    end
    assign rd_word = ((cmd.mode == MODE_READ) && (status_pre == ST_OK)) ?
                     rd64[VALUE_W-1:0] : '0;
    assign fill8   = 8'(count_next);

    // lowest set match bit
    always_comb
    begin
        enc_hit = 1'b0;
        enc_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                enc_hit = 1'b1;
                enc_idx = IDX_W'(i);
            end
        end
    end
    assign found8 = 8'(enc_idx);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // first-stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_find_reg   <= (cmd.mode == MODE_FIND);
            s1_status_reg <= status_pre;
            s1_rd_reg     <= rd_word;
            s1_fill_reg   <= fill8[FILL_W-1:0];
        end
    end

    // response register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg.read_value <= s1_rd_reg;
            rsp_reg.fill_count <= s1_fill_reg;
            if (s1_find_reg && (s1_status_reg == ST_OK))
            begin
                rsp_reg.status      <= enc_hit ? ST_OK : ST_NOT_FOUND;
                rsp_reg.found_index <= enc_hit ? found8[FOUND_W-1:0] : '0;
            end
            else
            begin
                rsp_reg.status      <= s1_status_reg;
                rsp_reg.found_index <= '0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // fill count stays within the store
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count beyond capacity");

    // fill count moves only on an accepted command word
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(accept))
        else $error("fill count changed without a command");

    // a full status is only decided at full capacity
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (status_pre == ST_FULL) |=> (count_reg == FULL_CNT))
        else $error("full status below capacity");

    // a new response comes only from a staged command
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(s1_valid_reg))
        else $error("response without staged command");
`endif

endmodule

`default_nettype wire
